/* rtl/core/pfb_pkg.sv */
// Shared constants, types and the helper function of the palettized frame buffer bus port.
package pfb_pkg;

  // Address map.
  localparam logic [31:0] FRAME_BASE   = 32'h0000_0000;
  localparam int unsigned FRAME_BYTES  = 8192;
  localparam logic [31:0] PALETTE_BASE = 32'd27072;
  localparam int unsigned PAL_WINDOW   = 64;

  localparam int unsigned PAL_ENTRIES = 16;
  localparam int unsigned COLOUR_W    = 24;
  localparam logic [7:0]  ALPHA_BYTE  = 8'hff;

  // One frame word holds an even/odd pixel pair and a shared written flag.
  localparam int unsigned PAIR_W   = 2 * COLOUR_W + 1;
  localparam int unsigned FRAME_AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [FRAME_AW-1:0] FRAME_LAST = FRAME_AW'(FRAME_BYTES - 1);

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [PAL_ENTRIES-1:0][COLOUR_W-1:0] palette_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_PAL_RD,
    K_PAL_WR,
    K_FRM_RD,
    K_FRM_WR
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [3:0]          pal_entry;
    logic [1:0]          pal_byte;
    logic [FRAME_AW-1:0] frame_index;
    logic [7:0]          data;
  } item_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FWRITE,
    S_FREAD
  } state_t;

  // Lowest palette index holding the colour; unwritten pixels and misses give zero.
  function automatic logic [3:0] colour_to_index(logic written, colour_t colour,
                                                 palette_t pal);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = PAL_ENTRIES - 1; i >= 0; i--) begin
      if (pal[i] == colour) begin
        idx = 4'(i);
      end
    end
    return written ? idx : 4'd0;
  endfunction

endpackage

/* rtl/core/pfb_if.sv */
// Valid/ready channel interfaces for bus requests and their responses.
interface pfb_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] address;
  logic [7:0]  write_data;

  modport source (output valid, op, address, write_data, input ready);
  modport sink (input valid, op, address, write_data, output ready);
endinterface

interface pfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       frame_hit;

  modport source (output valid, read_data, frame_hit, input ready);
  modport sink (input valid, read_data, frame_hit, output ready);
endinterface

/* rtl/core/pfb_ram.sv */
// Generic simple dual-port RAM with a registered read port.
module pfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pfb_front.sv */
// Front end: accepts bus requests and classifies them by address window and operation.
module pfb_front (
  pfb_req_if.sink        req,
  input  logic           clear_done,
  output logic           push_valid,
  input  logic           push_ready,
  output pfb_pkg::item_t push_item
);
  import pfb_pkg::*;

  logic [32:0] addr_ext;
  logic [32:0] pal_diff;
  logic [32:0] frm_diff;
  logic        pal_hit;
  logic        frm_hit;

  assign addr_ext = {1'b0, req.address};
  assign pal_diff = addr_ext - {1'b0, PALETTE_BASE};
  assign frm_diff = addr_ext - {1'b0, FRAME_BASE};

  // The palette window is checked first and wins where the windows overlap.
  assign pal_hit = (addr_ext >= {1'b0, PALETTE_BASE}) && (pal_diff < 33'(PAL_WINDOW));
  assign frm_hit = (addr_ext >= {1'b0, FRAME_BASE}) && (frm_diff < 33'(FRAME_BYTES));

  always_comb begin
    push_item.pal_entry   = pal_diff[5:2];
    push_item.pal_byte    = pal_diff[1:0];
    push_item.frame_index = frm_diff[FRAME_AW-1:0];
    push_item.data        = req.write_data;
    priority if (pal_hit) begin
      if (!req.op) begin
        push_item.kind = K_PAL_RD;
      end else if (pal_diff[1:0] != 2'd0) begin
        push_item.kind = K_PAL_WR;
      end else begin
        // Writes to the alpha byte are dropped.
        push_item.kind = K_NONE;
      end
    end else if (frm_hit) begin
      push_item.kind = req.op ? K_FRM_WR : K_FRM_RD;
    end else begin
      push_item.kind = K_NONE;
    end
  end

  assign push_valid = req.valid && clear_done;
  assign req.ready  = push_ready && clear_done;

endmodule

/* rtl/core/pfb_queue.sv */
// Two-entry request queue between the front end and the back end.
module pfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pfb_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output pfb_pkg::item_t pop_item
);
  import pfb_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* rtl/core/pfb_back.sv */
// Back end: palette registers, frame store sequencing and the response register.
module pfb_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  pfb_pkg::item_t q_item,
  output logic           pop,
  output logic           clear_done,
  pfb_rsp_if.source      rsp
);
  import pfb_pkg::*;

  state_t              state;
  state_t              state_next;
  palette_t            palette;
  colour_t             pal_rd;
  colour_t             pal_wr_colour;
  logic [3:0]          pal_idx;
  logic                pal_we;
  colour_t             hi_colour;
  logic [3:0]          lo_idx;
  logic [FRAME_AW-1:0] wr_index;
  logic                capture_write;
  logic [FRAME_AW-1:0] clear_addr;

  logic                ram_we;
  logic [FRAME_AW-1:0] ram_waddr;
  logic [PAIR_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [FRAME_AW-1:0] ram_raddr;
  logic [PAIR_W-1:0]   ram_rdata;

  logic                out_valid;
  logic [7:0]          out_rd;
  logic                out_hit;
  logic                out_load;
  logic [7:0]          out_rd_next;
  logic                out_hit_next;
  logic                slot_free;
  logic                frame_kind;
  logic [31:0]         pal_word;

  assign slot_free  = !out_valid || rsp.ready;
  assign frame_kind = (q_item.kind == K_FRM_RD) || (q_item.kind == K_FRM_WR);
  assign clear_done = (state != S_CLEAR);
  assign pal_rd     = palette[pal_idx];
  assign pal_word   = {ALPHA_BYTE, pal_rd};

  pfb_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(FRAME_BYTES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clear_addr == FRAME_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && q_item.kind == K_FRM_WR) begin
          state_next = S_FWRITE;
        end else if (q_valid && q_item.kind == K_FRM_RD) begin
          state_next = S_FREAD;
        end
      end
      S_FWRITE, S_FREAD: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // Palette byte update for a palette write (mirrored byte lane).
  always_comb begin
    pal_wr_colour = pal_rd;
    unique case (q_item.pal_byte)
      2'd1: pal_wr_colour[23:16] = q_item.data;
      2'd2: pal_wr_colour[15:8]  = q_item.data;
      2'd3: pal_wr_colour[7:0]   = q_item.data;
      2'd0: pal_wr_colour        = pal_rd;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop           = 1'b0;
    pal_idx       = q_item.pal_entry;
    pal_we        = 1'b0;
    capture_write = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = q_item.frame_index;
    ram_wdata     = {1'b1, hi_colour, pal_rd};
    ram_re        = 1'b0;
    ram_raddr     = q_item.frame_index;
    out_load      = 1'b0;
    out_rd_next   = 8'd0;
    out_hit_next  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        if (q_item.kind == K_FRM_WR) begin
          pal_idx = q_item.data[7:4];
        end
        if (q_valid && (slot_free || frame_kind)) begin
          pop = 1'b1;
          unique case (q_item.kind)
            K_PAL_RD: begin
              out_load = 1'b1;
              unique case (q_item.pal_byte)
                2'd0: out_rd_next = pal_word[7:0];
                2'd1: out_rd_next = pal_word[15:8];
                2'd2: out_rd_next = pal_word[23:16];
                2'd3: out_rd_next = pal_word[31:24];
              endcase
            end
            K_PAL_WR: begin
              out_load = 1'b1;
              pal_we   = 1'b1;
            end
            K_FRM_WR: begin
              capture_write = 1'b1;
            end
            K_FRM_RD: begin
              ram_re = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_FWRITE: begin
        // The request has already left the queue, so its word index comes from
        // the copy taken when it was popped.
        pal_idx   = lo_idx;
        ram_waddr = wr_index;
        ram_wdata = {1'b1, hi_colour, pal_rd};
        if (slot_free) begin
          ram_we       = 1'b1;
          out_load     = 1'b1;
          out_hit_next = 1'b1;
        end
      end
      S_FREAD: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_hit_next = 1'b1;
          out_rd_next  = {
            colour_to_index(ram_rdata[PAIR_W-1], ram_rdata[2*COLOUR_W-1:COLOUR_W], palette),
            colour_to_index(ram_rdata[PAIR_W-1], ram_rdata[COLOUR_W-1:0], palette)
          };
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < PAL_ENTRIES; i++) begin
        palette[i] <= {6{4'(i)}};
      end
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + FRAME_AW'(1);
      end
      if (pal_we) begin
        palette[pal_idx] <= pal_wr_colour;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture_write) begin
      hi_colour <= pal_rd;
      lo_idx    <= q_item.data[3:0];
      wr_index  <= q_item.frame_index;
    end
    if (out_load) begin
      out_rd  <= out_rd_next;
      out_hit <= out_hit_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rd;
  assign rsp.frame_hit = out_hit;

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !pop)
    else $error("queue popped during frame store clear");

  a_write_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != S_CLEAR) |-> ram_wdata[PAIR_W-1])
    else $error("frame write without written flag");

  a_hit_from_frame: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_hit_next) |-> (state == S_FWRITE || state == S_FREAD))
    else $error("frame hit reported outside a frame access");

endmodule

/* rtl/core/palettized_framebuffer_bus_port.sv */
// Top level of the palettized frame buffer bus port: front end, request queue and back end.
// Responses: a palette or unmapped request answers in the cycle after it leaves the queue;
//   a frame access then waits in S_FREAD or S_FWRITE (RAM read, or second palette lookup).
// Throughput: one request per cycle for palette and unmapped requests, when the response
//   sink is ready; a frame request holds the back-end sequencer until it is answered.
// Reset: synchronous, active high. After reset the frame store is cleared one word per
//   cycle, all FRAME_BYTES words, and no request is accepted until that is done.
module palettized_framebuffer_bus_port (
  input  logic      clk,
  input  logic      rst,
  pfb_req_if.sink   req,
  pfb_rsp_if.source rsp
);
  import pfb_pkg::*;

  // The front end decodes each request into a queue item: which window it hits, whether
  // it is a read or a write, the palette entry and byte, and the frame word index.
  // Alpha-byte palette writes and addresses outside both windows become empty items that
  // still produce a zero response, so every request gets exactly one response.
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;
  logic  clear_done;

  pfb_front u_front (
    .req       (req),
    .clear_done(clear_done),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  // The two-entry queue lets the front keep accepting requests while the back end
  // works through a frame access or waits on a stalled response.
  pfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (q_item)
  );

  // The back end owns the palette and the frame RAM. Each frame word stores both pixels
  // of a byte address with their palette colours and a written flag. A frame write looks
  // up the high nibble as it leaves the queue and the low nibble in S_FWRITE, then writes
  // the word. A frame read fetches the word, then maps both colours back to the lowest
  // matching palette index. The response register parts the back end from the sink.
  pfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop),
    .clear_done(clear_done),
    .rsp       (rsp)
  );

endmodule
